@@ src/wlpd_pkg.sv @@
// shared types and constants of the windowed long-press detector
package wlpd_pkg;

  localparam int CntW   = 16;
  localparam int BlinkW = 8;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;
  localparam int InTdataW = 8;
  localparam int OutTdataW = 24;

  localparam logic [CntW-1:0]   CntMax   = {CntW{1'b1}};
  localparam logic [BlinkW-1:0] BlinkMax = {BlinkW{1'b1}};

  localparam logic [CfgIdxW-1:0] CFG_WINDOW_TICKS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_TICKS   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BLINK_HALF   = 2'd2;

  localparam logic [CntW-1:0]   WINDOW_TICKS_RST = 16'd500;
  localparam logic [CntW-1:0]   HOLD_TICKS_RST   = 16'd300;
  localparam logic [BlinkW-1:0] BLINK_HALF_RST   = 8'd10;

  typedef enum logic [1:0] {
    OUTCOME_RUNNING = 2'd0,
    OUTCOME_RESET   = 2'd1,
    OUTCOME_CLOSED  = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [CntW-1:0]   window_ticks;
    logic [CntW-1:0]   hold_ticks;
    logic [BlinkW-1:0] blink_half_ticks;
  } cfg_t;

  typedef struct packed {
    logic [CntW-1:0] hold_count;
    outcome_t        outcome;
    logic            led_on;
  } res_t;

endpackage

@@ src/wlpd_cfg_regs.sv @@
// configuration registers of the long-press detector
module wlpd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [wlpd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [wlpd_pkg::CfgDataW-1:0]  cfg_wdata,
  output wlpd_pkg::cfg_t                 cfg
);
  import wlpd_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ticks     <= WINDOW_TICKS_RST;
      cfg_r.hold_ticks       <= HOLD_TICKS_RST;
      cfg_r.blink_half_ticks <= BLINK_HALF_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WINDOW_TICKS: cfg_r.window_ticks     <= cfg_wdata;
        CFG_HOLD_TICKS:   cfg_r.hold_ticks       <= cfg_wdata;
        CFG_BLINK_HALF:   cfg_r.blink_half_ticks <= cfg_wdata[BlinkW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/wlpd_core.sv @@
// detector state and per-tick next-state logic
module wlpd_core (
  input  logic            clk,
  input  logic            rst_n,
  input  wlpd_pkg::cfg_t  cfg,
  input  logic            tick,
  input  logic            button_level,
  input  logic            rearm,
  output wlpd_pkg::res_t  res
);
  import wlpd_pkg::*;

  logic [CntW-1:0]   window_count_r, window_count_nxt;
  logic [CntW-1:0]   press_count_r, press_count_nxt;
  logic [BlinkW-1:0] blink_phase_r, blink_phase_nxt;
  logic              led_r, led_nxt;
  logic              was_pressed_r, was_pressed_nxt;
  outcome_t          fin_r, fin_nxt;

  logic              in_win;
  logic              pressed;
  logic [BlinkW-1:0] bp_inc;
  logic [CntW-1:0]   pc_base;
  logic [CntW-1:0]   pc_inc;
  logic [CntW-1:0]   wc_inc;

  always_comb begin
    window_count_nxt = window_count_r;
    press_count_nxt  = press_count_r;
    blink_phase_nxt  = blink_phase_r;
    led_nxt          = led_r;
    was_pressed_nxt  = was_pressed_r;
    fin_nxt          = fin_r;
    pressed          = ~button_level;
    in_win           = window_count_r < cfg.window_ticks;
    bp_inc           = (blink_phase_r == BlinkMax) ? BlinkMax : blink_phase_r + 1'b1;
    pc_base          = was_pressed_r ? press_count_r : '0;
    pc_inc           = (pc_base == CntMax) ? CntMax : pc_base + 1'b1;
    wc_inc           = (window_count_r == CntMax) ? CntMax : window_count_r + 1'b1;
    if (rearm) begin
      window_count_nxt = '0;
      press_count_nxt  = '0;
      blink_phase_nxt  = '0;
      led_nxt          = 1'b0;
      was_pressed_nxt  = 1'b0;
      fin_nxt          = OUTCOME_RUNNING;
    end else if (fin_r == OUTCOME_RUNNING) begin
      if (!(in_win || was_pressed_r)) begin
        fin_nxt = OUTCOME_CLOSED;
        led_nxt = 1'b0;
      end else begin
        // blink during the window
        if (in_win) begin
          if (bp_inc >= cfg.blink_half_ticks) begin
            led_nxt         = ~led_r;
            blink_phase_nxt = '0;
          end else begin
            blink_phase_nxt = bp_inc;
          end
        end
        priority if (pressed) begin
          was_pressed_nxt = 1'b1;
          press_count_nxt = pc_inc;
          if (pc_inc >= cfg.hold_ticks) begin
            fin_nxt = OUTCOME_RESET;
            led_nxt = 1'b0;
          end else begin
            window_count_nxt = wc_inc;
          end
        end else if (was_pressed_r) begin
          press_count_nxt = '0;
          was_pressed_nxt = 1'b0;
          if (!in_win) begin
            fin_nxt = OUTCOME_CLOSED;
            led_nxt = 1'b0;
          end else begin
            window_count_nxt = wc_inc;
            if (!(wc_inc < cfg.window_ticks)) begin
              fin_nxt = OUTCOME_CLOSED;
              led_nxt = 1'b0;
            end
          end
        end else begin
          window_count_nxt = wc_inc;
          if (!(wc_inc < cfg.window_ticks)) begin
            fin_nxt = OUTCOME_CLOSED;
            led_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_count_r <= '0;
      press_count_r  <= '0;
      blink_phase_r  <= '0;
      led_r          <= 1'b0;
      was_pressed_r  <= 1'b0;
      fin_r          <= OUTCOME_RUNNING;
    end else if (tick) begin
      window_count_r <= window_count_nxt;
      press_count_r  <= press_count_nxt;
      blink_phase_r  <= blink_phase_nxt;
      led_r          <= led_nxt;
      was_pressed_r  <= was_pressed_nxt;
      fin_r          <= fin_nxt;
    end
  end

  assign res.led_on     = led_nxt;
  assign res.outcome    = fin_nxt;
  assign res.hold_count = press_count_nxt;

  // led is dark once the run has ended
  a_led_off_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_r != OUTCOME_RUNNING) |-> !led_r)
    else $error("led lit after run ended");

  // a finished run only leaves its outcome through rearm
  a_outcome_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ((fin_r != OUTCOME_RUNNING) && !(tick && rearm)) |=> $stable(fin_r))
    else $error("outcome changed without rearm");

  // rearm transaction clears the run
  a_rearm_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && rearm) |=> (fin_r == OUTCOME_RUNNING && press_count_r == '0 && !led_r))
    else $error("rearm did not clear state");

endmodule

@@ src/wlpd_out_buf.sv @@
// two-entry result register with skid stage
module wlpd_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wlpd_pkg::res_t  push_data,
  output logic            push_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output wlpd_pkg::res_t  out_data
);
  import wlpd_pkg::*;

  logic main_valid_r, skid_valid_r;
  res_t main_data_r, skid_data_r;
  logic main_free;

  assign main_free  = !main_valid_r || out_ready;
  assign push_ready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (main_free) begin
      main_valid_r <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

  // skid entry only holds data behind a full main entry
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry valid with empty main entry");

endmodule

@@ src/windowed_long_press_detector_unit.sv @@
// top level of the windowed long-press detector
//
// each input transaction is one tick carrying the sampled active-low button
// level and a rearm flag; each tick gives exactly one result transaction
// with the led drive level, the outcome code and the current hold count
// the result of a tick is formed combinationally from the tick and the
// detector state and registered in the result buffer; throughput: one tick
// per cycle while in_tready is high
// a two-entry result buffer lets one more tick in while the receiver stalls;
// in_tready drops only when both entries are full
// configuration is a plain write port: index 0 window length, 1 hold ticks,
// 2 blink half period; write only while no ticks are in flight
// reset (rst_n low, synchronous) restores the default register values,
// clears all detector state with the led off, outcome running, and empties
// the result buffer
module windowed_long_press_detector_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [wlpd_pkg::InTdataW-1:0]   in_tdata,   // button_level, rearm
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [wlpd_pkg::OutTdataW-1:0]  out_tdata,  // hold_count[15:0], outcome[1:0], led_on
  input  logic                            cfg_wr_en,
  input  logic [wlpd_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [wlpd_pkg::CfgDataW-1:0]   cfg_wdata
);
  import wlpd_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic tick;

  assign tick = in_tvalid && in_tready;

  wlpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  wlpd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .tick         (tick),
    .button_level (in_tdata[0]),
    .rearm        (in_tdata[1]),
    .res          (res)
  );

  wlpd_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (tick),
    .push_data  (res),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = {{(OutTdataW - $bits(res_t)){1'b0}}, out_res};

endmodule
